### hw/rtl/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg
// shared constants, codes and control types of the block allocator
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int NWORDS     = MAX_BLOCKS / WORD_BITS;
  localparam int WP_W       = $clog2(NWORDS);
  localparam int MAX_ALLOC  = 64;
  localparam int CNT_W      = 7;
  localparam int BC_W       = 11;
  localparam int KIND_W     = 3;
  localparam int ST_W       = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RETAIN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROP    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD    = 2'd2;

  typedef struct packed {
    logic            latch;
    logic            clr_step;
    logic            exec_single;
    logic            emit_code;
    logic [ST_W-1:0] code;
    logic            alloc_init;
    logic            load;
    logic            issue;
    logic            wb;
  } rba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic bad_req;
    logic cnt_zero;
    logic cnt_over;
    logic not_enough;
    logic word_zero;
    logic remain_zero;
  } rba_stat_t;

endpackage

### hw/rtl/rba_ctrl.sv
// ----------------------------------------------------------------------------
// rba_ctrl
// sequencer of the block allocator: clearing pass, request decode, free scan
// ----------------------------------------------------------------------------
module rba_ctrl import rba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      cfg_wr,
  input  rba_stat_t stat,
  output logic      busy,
  output rba_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_LOAD,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (stat.is_alloc) begin
          if (stat.cnt_zero) begin
            cmd.emit_code = 1'b1;
            cmd.code      = ST_OK;
          end else if (stat.cnt_over) begin
            cmd.emit_code = 1'b1;
            cmd.code      = ST_BAD;
          end else if (stat.not_enough) begin
            cmd.emit_code = 1'b1;
            cmd.code      = ST_NOFREE;
          end else begin
            cmd.alloc_init = 1'b1;
            state_nxt      = S_FETCH;
          end
        end else if (stat.bad_req) begin
          cmd.emit_code = 1'b1;
          cmd.code      = ST_BAD;
        end else begin
          cmd.exec_single = 1'b1;
        end
      end
      S_FETCH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.remain_zero || stat.word_zero) begin
          cmd.wb    = 1'b1;
          state_nxt = stat.remain_zero ? S_IDLE : S_FETCH;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    if (cfg_wr) begin
      cmd       = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r && !cfg_wr) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter decode");

endmodule

### hw/rtl/rba_dp.sv
// ----------------------------------------------------------------------------
// rba_dp
// datapath of the block allocator: free map, count memories, totals, results
// ----------------------------------------------------------------------------
module rba_dp import rba_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  logic [BC_W-1:0]   cfg_wdata,
  input  rba_cmd_t          cmd,
  output rba_stat_t         stat,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [CNT_W-1:0]  in_count,
  input  logic [IDX_W-1:0]  in_block_index,
  output logic              out_strobe,
  output logic [ST_W-1:0]   out_status,
  output logic              out_has_block,
  output logic [IDX_W-1:0]  out_allocated_block,
  output logic              out_last,
  output logic [IDX_W-1:0]  out_free_blocks,
  output logic [IDX_W-1:0]  out_avail_blocks,
  output logic [BC_W-1:0]   block_count
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  function automatic logic [BIT_W-1:0] low_bit_idx(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] iso;
    logic [BIT_W-1:0]     idx;
    iso = w & (~w + WORD_BITS'(1));
    idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (iso[j]) idx = idx | BIT_W'(j);
    end
    return idx;
  endfunction

  logic [WORD_BITS-1:0]  fmap_mem [NWORDS];
  logic [COUNT_BITS-1:0] hold_mem [MAX_BLOCKS];
  logic [COUNT_BITS-1:0] user_mem [MAX_BLOCKS];

  logic [WORD_BITS-1:0]  fmap_rd_r;
  logic [COUNT_BITS-1:0] hold_rd_r, user_rd_r;

  logic [BC_W-1:0]   block_count_r, free_total_r, avail_total_r;
  logic [BC_W-1:0]   free_total_nxt, avail_total_nxt, bc_clamp;
  logic [KIND_W-1:0] kind_r;
  logic [CNT_W-1:0]  cnt_r, remain_r;
  logic [IDX_W-1:0]  bidx_r, clr_ptr_r;
  logic [WP_W-1:0]   wp_r;
  logic [WORD_BITS-1:0] word_r, clr_word, set_word;
  logic              s2_valid_r, s2_last_r;
  logic [IDX_W-1:0]  s2_idx_r;

  logic              out_strobe_r, out_has_block_r, out_last_r;
  logic [ST_W-1:0]   out_status_r;
  logic [IDX_W-1:0]  out_block_r, out_free_r, out_avail_r;

  logic [IDX_W-1:0]  issue_idx, cnt_raddr, cnt_waddr;
  logic [WP_W-1:0]   fmap_raddr, fmap_waddr;
  logic [WORD_BITS-1:0] fmap_wdata;
  logic              fmap_we;
  logic              h_inc, h_dec, u_inc, u_dec, h_sat, u_sat, h_we, u_we, freeing;
  logic [COUNT_BITS-1:0] h_new, u_new, hold_wdata, user_wdata;
  logic              hold_we, user_we, upd_emit, fbit;

  assign issue_idx  = {wp_r, low_bit_idx(word_r)};
  assign cnt_raddr  = cmd.latch ? in_block_index : issue_idx;
  assign fmap_raddr = cmd.latch ? in_block_index[IDX_W-1:BIT_W] : wp_r;

  // clamp of the pool size
  always_comb begin
    if (cfg_wdata < BC_W'(2)) begin
      bc_clamp = BC_W'(2);
    end else if (cfg_wdata > BC_W'(MAX_BLOCKS)) begin
      bc_clamp = BC_W'(MAX_BLOCKS);
    end else begin
      bc_clamp = cfg_wdata;
    end
  end

  // initial free word for the clearing pass
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      clr_word[j] = ({clr_ptr_r[WP_W-1:0], BIT_W'(j)} != '0) &&
                    ({1'b0, clr_ptr_r[WP_W-1:0], BIT_W'(j)} < block_count_r);
    end
  end

  // count update shared by allocation and single-block requests
  always_comb begin
    h_inc = s2_valid_r ||
            (cmd.exec_single && (kind_r == KIND_RETAIN || kind_r == KIND_ADD));
    h_dec = cmd.exec_single && (kind_r == KIND_RELEASE || kind_r == KIND_DROP);
    u_inc = s2_valid_r || (cmd.exec_single && kind_r == KIND_RETAIN);
    u_dec = cmd.exec_single && kind_r == KIND_RELEASE;

    h_sat = (h_inc && hold_rd_r == COUNT_MAX) || (h_dec && hold_rd_r == '0);
    u_sat = (u_inc && user_rd_r == COUNT_MAX) || (u_dec && user_rd_r == '0);
    h_new = h_inc ? hold_rd_r + COUNT_ONE : hold_rd_r - COUNT_ONE;
    u_new = u_inc ? user_rd_r + COUNT_ONE : user_rd_r - COUNT_ONE;
    h_we  = (h_inc || h_dec) && !h_sat;
    u_we  = (u_inc || u_dec) && !u_sat;

    fbit     = fmap_rd_r[bidx_r[BIT_W-1:0]];
    freeing  = h_dec && !h_sat && hold_rd_r == COUNT_ONE && !fbit;
    set_word = fmap_rd_r | (WORD_BITS'(1) << bidx_r[BIT_W-1:0]);

    free_total_nxt = free_total_r;
    if (s2_valid_r) begin
      free_total_nxt = free_total_r - BC_W'(1);
    end else if (freeing) begin
      free_total_nxt = free_total_r + BC_W'(1);
    end

    avail_total_nxt = avail_total_r;
    if (u_inc && !u_sat && user_rd_r == '0 && avail_total_r != '0) begin
      avail_total_nxt = avail_total_r - BC_W'(1);
    end else if (u_dec && !u_sat && user_rd_r == COUNT_ONE) begin
      avail_total_nxt = avail_total_r + BC_W'(1);
    end

    upd_emit = s2_valid_r || cmd.exec_single;
  end

  // memory write port selection
  always_comb begin
    if (cmd.clr_step) begin
      cnt_waddr  = clr_ptr_r;
      hold_wdata = '0;
      user_wdata = '0;
      hold_we    = 1'b1;
      user_we    = 1'b1;
    end else begin
      cnt_waddr  = s2_valid_r ? s2_idx_r : bidx_r;
      hold_wdata = h_new;
      user_wdata = u_new;
      hold_we    = h_we;
      user_we    = u_we;
    end

    fmap_we    = 1'b0;
    fmap_waddr = wp_r;
    fmap_wdata = word_r;
    if (cmd.clr_step) begin
      fmap_we    = (clr_ptr_r[IDX_W-1:WP_W] == '0);
      fmap_waddr = clr_ptr_r[WP_W-1:0];
      fmap_wdata = clr_word;
    end else if (cmd.wb) begin
      fmap_we = 1'b1;
    end else if (freeing) begin
      fmap_we    = 1'b1;
      fmap_waddr = bidx_r[IDX_W-1:BIT_W];
      fmap_wdata = set_word;
    end
  end

  always_ff @(posedge clk) begin
    fmap_rd_r <= fmap_mem[fmap_raddr];
    if (fmap_we) begin
      fmap_mem[fmap_waddr] <= fmap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    hold_rd_r <= hold_mem[cnt_raddr];
    user_rd_r <= user_mem[cnt_raddr];
    if (hold_we) begin
      hold_mem[cnt_waddr] <= hold_wdata;
    end
    if (user_we) begin
      user_mem[cnt_waddr] <= user_wdata;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BC_W'(MAX_BLOCKS);
      free_total_r  <= BC_W'(MAX_BLOCKS - 1);
      avail_total_r <= BC_W'(MAX_BLOCKS - 1);
      clr_ptr_r     <= '0;
      s2_valid_r    <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      s2_valid_r   <= cmd.issue;
      out_strobe_r <= upd_emit || cmd.emit_code;
      if (cfg_wr) begin
        block_count_r <= bc_clamp;
        free_total_r  <= bc_clamp - BC_W'(1);
        avail_total_r <= bc_clamp - BC_W'(1);
        clr_ptr_r     <= '0;
      end else begin
        free_total_r  <= free_total_nxt;
        avail_total_r <= avail_total_nxt;
        if (cmd.clr_step) begin
          clr_ptr_r <= clr_ptr_r + IDX_W'(1);
        end
      end
    end
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      cnt_r  <= in_count;
      bidx_r <= in_block_index;
    end
    if (cmd.alloc_init) begin
      wp_r     <= '0;
      remain_r <= cnt_r;
    end else begin
      if (cmd.wb) begin
        wp_r <= wp_r + WP_W'(1);
      end
      if (cmd.issue) begin
        remain_r <= remain_r - CNT_W'(1);
      end
    end
    if (cmd.load) begin
      word_r <= fmap_rd_r;
    end else if (cmd.issue) begin
      word_r <= word_r & (word_r - WORD_BITS'(1));
    end
    s2_idx_r  <= issue_idx;
    s2_last_r <= (remain_r == CNT_W'(1));
  end

  // result registers
  always_ff @(posedge clk) begin
    if (upd_emit) begin
      out_status_r    <= (h_sat || u_sat) ? ST_BAD : ST_OK;
      out_has_block_r <= s2_valid_r;
      out_block_r     <= s2_valid_r ? s2_idx_r : '0;
      out_last_r      <= s2_valid_r ? s2_last_r : 1'b1;
      out_free_r      <= free_total_nxt[IDX_W-1:0];
      out_avail_r     <= avail_total_nxt[IDX_W-1:0];
    end else if (cmd.emit_code) begin
      out_status_r    <= cmd.code;
      out_has_block_r <= 1'b0;
      out_block_r     <= '0;
      out_last_r      <= 1'b1;
      out_free_r      <= free_total_r[IDX_W-1:0];
      out_avail_r     <= avail_total_r[IDX_W-1:0];
    end
  end

  always_comb begin
    stat             = '0;
    stat.clr_last    = (clr_ptr_r == IDX_W'(MAX_BLOCKS - 1));
    stat.is_alloc    = (kind_r == KIND_ALLOC);
    stat.bad_req     = (kind_r > KIND_DROP) || (bidx_r == '0) ||
                       ({1'b0, bidx_r} >= block_count_r);
    stat.cnt_zero    = (cnt_r == '0);
    stat.cnt_over    = (cnt_r > CNT_W'(MAX_ALLOC));
    stat.not_enough  = (free_total_r < {{(BC_W-CNT_W){1'b0}}, cnt_r});
    stat.word_zero   = (word_r == '0);
    stat.remain_zero = (remain_r == '0);
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_has_block       = out_has_block_r;
  assign out_allocated_block = out_block_r;
  assign out_last            = out_last_r;
  assign out_free_blocks     = out_free_r;
  assign out_avail_blocks    = out_avail_r;
  assign block_count         = block_count_r;

  a_free_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r < block_count_r)
    else $error("free total exceeds pool size");

  a_alloc_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_idx_r != '0) && ({1'b0, s2_idx_r} < block_count_r))
    else $error("allocated block outside the pool");

  a_blockless_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_has_block_r) |-> out_last_r)
    else $error("result without block not marked last");

endmodule

### hw/rtl/refcounted_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// refcounted_block_allocator_unit
// reference-counted allocator for a pool of cache blocks, block 0 reserved
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; kinds are allocate,
// release, retain, add holder and drop holder
// each result shows on the out_ ports for one cycle with out_strobe high;
// the receiver takes every result, there is no backpressure
// release, retain, add and drop: the holder and user count memories are
// read when the item is taken and written in the decode state, which
// registers the result; the next item is taken once back in idle
// allocate: free map scanned one 32-bit word at a time, each word fetched,
// loaded, then scanned one block per cycle and written back; one result per
// block, back to back within a word, the last one flagged with out_last
// requests that fail a check give a single result from the decode state
// reset and every write of block_count start a clearing pass over all 1024
// entries of the count memories and the free map; busy stays high during
// the pass, register writes are still taken
// block_count lies at byte address 0 of the register port
// ----------------------------------------------------------------------------
module refcounted_block_allocator_unit import rba_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [CNT_W-1:0]  in_count,
  input  logic [IDX_W-1:0]  in_block_index,
  output logic              out_strobe,
  output logic [ST_W-1:0]   out_status,
  output logic              out_has_block,
  output logic [IDX_W-1:0]  out_allocated_block,
  output logic              out_last,
  output logic [IDX_W-1:0]  out_free_blocks,
  output logic [IDX_W-1:0]  out_avail_blocks,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  rba_cmd_t        cmd;
  rba_stat_t       stat;
  logic            cfg_wr;
  logic [BC_W-1:0] block_count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == 2'd0) ? {{(32-BC_W){1'b0}}, block_count}
                                  : {{(32-BC_W){1'b0}}, block_count};

  rba_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  rba_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr              (cfg_wr),
    .cfg_wdata           (pwdata[BC_W-1:0]),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_kind),
    .in_count            (in_count),
    .in_block_index      (in_block_index),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_has_block       (out_has_block),
    .out_allocated_block (out_allocated_block),
    .out_last            (out_last),
    .out_free_blocks     (out_free_blocks),
    .out_avail_blocks    (out_avail_blocks),
    .block_count         (block_count)
  );

endmodule

### bench/tb_refcounted_block_allocator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_block_allocator_unit
// self-checking bench for the reference-counted block allocator
// ----------------------------------------------------------------------------
// requests are queued by an initial block and driven on the start/busy
// handshake with random gaps; a predictor keeps its own free map, holder
// and user counts and totals, and queues the results each accepted request
// should produce; the monitor compares every strobed result field by field
// with the oldest queued result
// the pool size register is rewritten between phases, through the
// low and high extremes, out-of-range values and a random small pool
// ----------------------------------------------------------------------------
module tb_refcounted_block_allocator_unit;
  import rba_pkg::*;

  localparam int COUNT_BITS = 8;
  localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
  localparam int IDLE_LIMIT = 20000;

  localparam logic [1:0] REG_BLOCK_COUNT = 2'd0;

  localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  index;
  } alloc_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             has_block;
    logic [IDX_W-1:0] block;
    logic             last;
    logic [IDX_W-1:0] free_n;
    logic [IDX_W-1:0] avail_n;
  } alloc_grant_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [CNT_W-1:0]  in_count = '0;
  logic [IDX_W-1:0]  in_block_index = '0;
  logic              out_strobe;
  logic [ST_W-1:0]   out_status;
  logic              out_has_block;
  logic [IDX_W-1:0]  out_allocated_block;
  logic              out_last;
  logic [IDX_W-1:0]  out_free_blocks;
  logic [IDX_W-1:0]  out_avail_blocks;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  refcounted_block_allocator_unit #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_count(in_count), .in_block_index(in_block_index),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_has_block(out_has_block), .out_allocated_block(out_allocated_block),
    .out_last(out_last), .out_free_blocks(out_free_blocks),
    .out_avail_blocks(out_avail_blocks),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  alloc_req_t   request_queue[$];
  alloc_grant_t expected_grants[$];
  int           issued_count = 0;
  int           accepted_count = 0;
  int           mismatches = 0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;

  // predictor state
  int unsigned pool_size;
  int unsigned free_total;
  int unsigned avail_total;
  bit          free_bit [MAX_BLOCKS];
  int unsigned holders [MAX_BLOCKS];
  int unsigned users [MAX_BLOCKS];

  function automatic void reset_pool(input int unsigned value);
    int unsigned n;
    n = value & 32'h7ff;
    if (n < 2) n = 2;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    pool_size = n;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      holders[i] = 0;
      users[i] = 0;
      free_bit[i] = (i >= 1 && i < n);
    end
    free_total = n - 1;
    avail_total = n - 1;
  endfunction

  function automatic bit holder_inc(input int unsigned b);
    if (holders[b] >= COUNT_MAX) return 1'b1;
    holders[b]++;
    return 1'b0;
  endfunction

  function automatic bit holder_dec(input int unsigned b);
    if (holders[b] == 0) return 1'b1;
    holders[b]--;
    if (holders[b] == 0 && !free_bit[b]) begin
      free_bit[b] = 1'b1;
      free_total++;
    end
    return 1'b0;
  endfunction

  function automatic bit user_inc(input int unsigned b);
    if (users[b] >= COUNT_MAX) return 1'b1;
    users[b]++;
    if (users[b] == 1 && avail_total > 0) avail_total--;
    return 1'b0;
  endfunction

  function automatic bit user_dec(input int unsigned b);
    if (users[b] == 0) return 1'b1;
    users[b]--;
    if (users[b] == 0) avail_total++;
    return 1'b0;
  endfunction

  function automatic void push_grant(input logic [ST_W-1:0] status, input bit has,
                                     input int unsigned blk, input bit last);
    alloc_grant_t g;
    g.status = status;
    g.has_block = has;
    g.block = IDX_W'(blk);
    g.last = last;
    g.free_n = IDX_W'(free_total);
    g.avail_n = IDX_W'(avail_total);
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  function automatic void account_request(input alloc_req_t r);
    int unsigned got;
    bit          sat;
    got = 0;
    sat = 1'b0;
    if (r.kind == KIND_ALLOC) begin
      if (r.count == 0) begin
        push_grant(ST_OK, 1'b0, 0, 1'b1);
      end else if (r.count > MAX_ALLOC) begin
        push_grant(ST_BAD, 1'b0, 0, 1'b1);
      end else if (free_total < r.count) begin
        push_grant(ST_NOFREE, 1'b0, 0, 1'b1);
      end else begin
        for (int i = 1; i < pool_size && got < r.count; i++) begin
          if (free_bit[i]) begin
            free_bit[i] = 1'b0;
            free_total--;
            sat = holder_inc(i);
            sat = user_inc(i) | sat;
            got++;
            push_grant(sat ? ST_BAD : ST_OK, 1'b1, i, got == r.count);
          end
        end
      end
    end else if (r.kind > KIND_DROP || r.index == 0 || r.index >= pool_size) begin
      push_grant(ST_BAD, 1'b0, 0, 1'b1);
    end else begin
      case (r.kind)
        KIND_RELEASE: begin
          sat = user_dec(r.index);
          sat = holder_dec(r.index) | sat;
        end
        KIND_RETAIN: begin
          sat = holder_inc(r.index);
          sat = user_inc(r.index) | sat;
        end
        KIND_ADD: sat = holder_inc(r.index);
        default:  sat = holder_dec(r.index);
      endcase
      push_grant(sat ? ST_BAD : ST_OK, 1'b0, 0, 1'b1);
    end
  endfunction

  function automatic void push_req(input logic [KIND_W-1:0] kind, input int unsigned count,
                                   input int unsigned index);
    alloc_req_t r;
    r.kind = kind;
    r.count = CNT_W'(count);
    r.index = IDX_W'(index);
    request_queue.insert(request_queue.size(), r);
  endfunction

  // mostly short allocations and count updates on low, likely live blocks
  function automatic void add_random_requests(input int n);
    int unsigned      roll;
    int unsigned      hi;
    int unsigned      cnt;
    int unsigned      idx;
    logic [KIND_W-1:0] k;
    for (int j = 0; j < n; j++) begin
      hi = (pool_size - 1 < 160) ? pool_size - 1 : 160;
      roll = $urandom_range(0, 99);
      if (roll < 30) k = KIND_ALLOC;
      else if (roll < 55) k = KIND_RELEASE;
      else if (roll < 70) k = KIND_RETAIN;
      else if (roll < 82) k = KIND_ADD;
      else if (roll < 94) k = KIND_DROP;
      else k = KIND_W'($urandom_range(KIND_RSVD5, KIND_RSVD7));
      roll = $urandom_range(0, 99);
      if (roll < 8) cnt = 0;
      else if (roll < 60) cnt = $urandom_range(1, 8);
      else if (roll < 82) cnt = $urandom_range(1, MAX_ALLOC);
      else if (roll < 90) cnt = MAX_ALLOC;
      else cnt = $urandom_range(MAX_ALLOC + 1, 127);
      roll = $urandom_range(0, 99);
      if (roll < 75) idx = $urandom_range(1, hi);
      else if (roll < 90) idx = $urandom_range(0, MAX_BLOCKS - 1);
      else begin
        case ($urandom_range(0, 3))
          0: idx = 0;
          1: idx = pool_size - 1;
          2: idx = pool_size & (MAX_BLOCKS - 1);
          default: idx = MAX_BLOCKS - 1;
        endcase
      end
      push_req(k, cnt, idx);
    end
  endfunction

  function automatic int pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : drive_requests
    alloc_req_t taken;
    alloc_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        taken.kind = in_kind;
        taken.count = in_count;
        taken.index = in_block_index;
        account_request(taken);
        accepted_count++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (request_queue.size() > 0) begin
        nxt = request_queue.pop_front();
        issued_count++;
        in_kind <= nxt.kind;
        in_count <= nxt.count;
        in_block_index <= nxt.index;
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_grants
    alloc_grant_t want;
    if (rst_n && out_strobe) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding");
      end else begin
        want = expected_grants.pop_front();
        check_field("status", want.status, out_status);
        check_field("has_block", want.has_block, out_has_block);
        check_field("allocated_block", want.block, out_allocated_block);
        check_field("last", want.last, out_last);
        check_field("free_blocks", want.free_n, out_free_blocks);
        check_field("avail_blocks", want.avail_n, out_avail_blocks);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (request_queue.size() > 0 || accepted_count != issued_count ||
           expected_grants.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_block_count(input int unsigned value);
    wait_drained();
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_BLOCK_COUNT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reset_pool(value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    reset_pool(MAX_BLOCKS);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // edge cases on the pool as it comes out of reset
    push_req(KIND_ALLOC, 0, MAX_BLOCKS - 1);
    push_req(KIND_ALLOC, 127, 0);
    push_req(KIND_ALLOC, MAX_ALLOC + 1, 0);
    push_req(KIND_ALLOC, 96, 0);
    push_req(KIND_ALLOC, MAX_ALLOC, 0);
    push_req(KIND_ALLOC, 1, 0);
    push_req(KIND_RELEASE, 0, 65);
    push_req(KIND_RETAIN, 0, 1);
    push_req(KIND_RELEASE, 0, 1);
    push_req(KIND_ADD, 0, 2);
    push_req(KIND_DROP, 0, 2);
    push_req(KIND_DROP, 0, 2);
    push_req(KIND_RELEASE, 0, 2);
    push_req(KIND_RELEASE, 0, 300);
    push_req(KIND_ADD, 0, 500);
    push_req(KIND_DROP, 0, 500);
    push_req(KIND_RELEASE, 0, 0);
    push_req(KIND_RETAIN, 0, MAX_BLOCKS - 1);
    push_req(KIND_DROP, 0, MAX_BLOCKS - 1);
    push_req(KIND_RSVD5, 0, 341);
    push_req(KIND_RSVD6, 0, 682);
    push_req(KIND_RSVD7, 0, 512);
    push_req(KIND_DROP, 0, 0);
    push_req(KIND_ALLOC, MAX_ALLOC, 0);
    add_random_requests(20);

    // smallest pool: one usable block
    write_block_count(2);
    push_req(KIND_ALLOC, 1, 0);
    push_req(KIND_ALLOC, 1, 0);
    push_req(KIND_RELEASE, 0, 1);
    push_req(KIND_RELEASE, 0, 2);
    push_req(KIND_RETAIN, 0, 1);
    push_req(KIND_ALLOC, 2, 0);
    push_req(KIND_ALLOC, 1, 0);
    add_random_requests(8);

    // out-of-range sizes are clamped
    write_block_count(0);
    add_random_requests(4);
    write_block_count(2047);
    push_req(KIND_RETAIN, 0, MAX_BLOCKS - 1);
    add_random_requests(4);

    write_block_count($urandom_range(8, 48));
    add_random_requests(16);

    write_block_count(MAX_BLOCKS);
    add_random_requests(16);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rba_pkg.sv
hw/rtl/rba_ctrl.sv
hw/rtl/rba_dp.sv
hw/rtl/refcounted_block_allocator_unit.sv
bench/tb_refcounted_block_allocator_unit.sv
